### sv/median_wrap_angle_tracker_macros.svh
// ----------------------------------------------------------------------------
// Median wrap angle tracker - assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_WRAP_ANGLE_TRACKER_MACROS_SVH
`define MEDIAN_WRAP_ANGLE_TRACKER_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define MWAT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define MWAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/mwat_pkg.sv
// ----------------------------------------------------------------------------
// mwat_pkg
// Widths, register indexes and shared types of the median wrap angle tracker.
// ----------------------------------------------------------------------------
package mwat_pkg;

    localparam int WINDOW_DEPTH = 5;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int MED_IDX      = WINDOW_DEPTH / 2;

    localparam int PULSE_W = 17;
    localparam int GAIN_W  = 16;
    localparam int Q8_W    = 15;
    localparam int TURN_W  = 16;
    localparam int ANGLE_W = 32;
    localparam int ACC_W   = 34;
    localparam int PROD_W  = PULSE_W + GAIN_W;
    localparam int SPAN_PROD_W = 2 * Q8_W;

    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 3;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DUTY_GAIN    = 3'd0,
        REG_JUMP_THRESH  = 3'd1,
        REG_DUTY_MIN     = 3'd2,
        REG_DUTY_MAX     = 3'd3,
        REG_START_OFFSET = 3'd4,
        REG_TURN_SPAN    = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  duty_gain;
        logic [PULSE_W-1:0] jump_threshold;
        logic [Q8_W-1:0]    duty_min_q8;
        logic [Q8_W-1:0]    duty_max_q8;
        logic [Q8_W-1:0]    start_offset_q8;
        logic [Q8_W-1:0]    turn_span_q8;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

### sv/mwat_fifo.sv
// ----------------------------------------------------------------------------
// mwat_fifo
// Short queue of window medians between the ranking front and the angle back.
// ----------------------------------------------------------------------------
module mwat_fifo (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr,
    input  logic [mwat_pkg::PULSE_W-1:0] wr_data,
    input  logic                         rd,
    output logic [mwat_pkg::PULSE_W-1:0] rd_data,
    output mwat_pkg::q_stat_t            stat
);
    import mwat_pkg::*;

    logic [PULSE_W-1:0] mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wptr_reg, wptr_next;
    logic [Q_PTR_W-1:0] rptr_reg, rptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               do_wr, do_rd;

    assign stat.full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_wr      = wr && !stat.full;
    assign do_rd      = rd && !stat.empty;
    assign rd_data    = mem[rptr_reg];

    always_comb
    begin
        wptr_next = do_wr ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = do_rd ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

### sv/mwat_front.sv
// ----------------------------------------------------------------------------
// mwat_front
// Sample window and median search: one candidate entry is ranked per cycle.
// ----------------------------------------------------------------------------
module mwat_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [mwat_pkg::PULSE_W-1:0] fb_width,
    output logic                         full,
    input  logic                         q_full,
    output logic                         q_push,
    output logic [mwat_pkg::PULSE_W-1:0] q_data
);
    import mwat_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_RANK = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t       state_reg, state_next;
    logic [PULSE_W-1:0] win_reg [WINDOW_DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   cand_reg, cand_next;
    logic [PULSE_W-1:0] med_reg;
    logic [PULSE_W-1:0] cand_val;
    logic [CNT_W-1:0]   lt_cnt, le_cnt;
    logic               found;
    logic               take;

    assign full   = (state_reg != F_IDLE);
    assign take   = push && (state_reg == F_IDLE);
    assign q_push = (state_reg == F_PUSH) && !q_full;
    assign q_data = med_reg;

    assign cand_val = win_reg[cand_reg];

    // Rank the candidate against the whole window.
    always_comb
    begin
        lt_cnt = '0;
        le_cnt = '0;
        for (int j = 0; j < WINDOW_DEPTH; j++)
        begin
            lt_cnt = lt_cnt + CNT_W'(win_reg[j] <  cand_val);
            le_cnt = le_cnt + CNT_W'(win_reg[j] <= cand_val);
        end
        found = ((lt_cnt <= CNT_W'(MED_IDX)) && (le_cnt > CNT_W'(MED_IDX)))
                || (cand_reg == PTR_W'(WINDOW_DEPTH - 1));
    end

    always_comb
    begin
        state_next = state_reg;
        cand_next  = cand_reg;
        wptr_next  = wptr_reg;
        case (state_reg)
            F_IDLE:
            begin
                cand_next = '0;
                if (push)
                begin
                    wptr_next  = (wptr_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
                    state_next = F_RANK;
                end
            end
            F_RANK:
            begin
                if (found)
                begin
                    state_next = F_PUSH;
                end
                else
                begin
                    cand_next = cand_reg + 1'b1;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == F_RANK) && found)
        begin
            med_reg <= cand_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            wptr_reg  <= '0;
            cand_reg  <= '0;
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            wptr_reg  <= wptr_next;
            cand_reg  <= cand_next;
            if (take)
            begin
                win_reg[wptr_reg] <= fb_width;
            end
        end
    end

endmodule

### sv/mwat_back.sv
// ----------------------------------------------------------------------------
// mwat_back
// Turn counting, duty scaling and angle unwrap with a result word register.
// ----------------------------------------------------------------------------
module mwat_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mwat_pkg::cfg_t               cfg,
    input  logic                         q_empty,
    input  logic [mwat_pkg::PULSE_W-1:0] q_data,
    output logic                         q_pop,
    output logic                         empty,
    input  logic                         pop,
    output logic [mwat_pkg::PULSE_W-1:0] median_width,
    output logic signed [mwat_pkg::TURN_W-1:0]  turn_count,
    output logic signed [mwat_pkg::ANGLE_W-1:0] unwrapped_angle,
    output logic                         saturated
);
    import mwat_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_TURN  = 4'b0010,
        B_SCALE = 4'b0100,
        B_ANGLE = 4'b1000
    } back_state_t;

    back_state_t              state_reg, state_next;
    logic [PULSE_W-1:0]       med_reg;
    logic [PULSE_W-1:0]       last_med_reg;
    logic signed [TURN_W-1:0] turns_reg, turns_next;
    logic                     sat_reg, turn_sat;
    logic [PROD_W-1:0]        prod_reg;
    logic [PULSE_W-1:0]       duty_reg;
    logic [SPAN_PROD_W-1:0]   span_prod_reg;
    logic [Q8_W-1:0]          extra_turns;
    logic                     wrap_fwd, wrap_back;
    logic [PULSE_W:0]         cur_plus_thr, prev_plus_thr;
    logic [ACC_W-1:0]         base, angle_sum;
    logic [ANGLE_W-1:0]       angle_clamped;
    logic                     angle_sat;
    logic                     out_valid_reg;
    logic                     out_free;

    assign empty    = !out_valid_reg;
    assign out_free = !out_valid_reg || pop;
    assign q_pop    = (state_reg == B_IDLE) && !q_empty;

    // Wrap detection against the previous median.
    always_comb
    begin
        cur_plus_thr  = {1'b0, med_reg} + {1'b0, cfg.jump_threshold};
        prev_plus_thr = {1'b0, last_med_reg} + {1'b0, cfg.jump_threshold};
        wrap_fwd      = cur_plus_thr < {1'b0, last_med_reg};
        wrap_back     = {1'b0, med_reg} > prev_plus_thr;
        turns_next    = turns_reg;
        turn_sat      = 1'b0;
        if (wrap_fwd)
        begin
            if (turns_reg != {1'b0, {(TURN_W-1){1'b1}}})
            begin
                turns_next = turns_reg + TURN_W'(1);
            end
            else
            begin
                turn_sat = 1'b1;
            end
        end
        else if (wrap_back)
        begin
            if (turns_reg != {1'b1, {(TURN_W-1){1'b0}}})
            begin
                turns_next = turns_reg - TURN_W'(1);
            end
            else
            begin
                turn_sat = 1'b1;
            end
        end
    end

    // Full turns beyond the first: turns-1 going forward, -(turns+1) going back.
    always_comb
    begin
        if (turns_reg > 0)
        begin
            extra_turns = turns_reg[Q8_W-1:0] - 1'b1;
        end
        else if (turns_reg < 0)
        begin
            extra_turns = ~turns_reg[Q8_W-1:0];
        end
        else
        begin
            extra_turns = '0;
        end
    end

    // Angle sum and clamp to the 32-bit range.
    always_comb
    begin
        if (turns_reg > 0)
        begin
            base = ACC_W'(cfg.duty_max_q8) - ACC_W'(cfg.start_offset_q8)
                 + ACC_W'(duty_reg) - ACC_W'(cfg.duty_min_q8);
        end
        else if (turns_reg < 0)
        begin
            base = ACC_W'(cfg.duty_min_q8) - ACC_W'(cfg.start_offset_q8)
                 - ACC_W'(cfg.duty_max_q8) + ACC_W'(duty_reg);
        end
        else
        begin
            base = ACC_W'(duty_reg) - ACC_W'(cfg.start_offset_q8);
        end
        angle_sum = base + ACC_W'(span_prod_reg);
        angle_sat = (angle_sum[ACC_W-1:ANGLE_W-1] != '0)
                    && (angle_sum[ACC_W-1:ANGLE_W-1] != '1);
        if (!angle_sat)
        begin
            angle_clamped = angle_sum[ANGLE_W-1:0];
        end
        else if (angle_sum[ACC_W-1])
        begin
            angle_clamped = {1'b1, {(ANGLE_W-1){1'b0}}};
        end
        else
        begin
            angle_clamped = {1'b0, {(ANGLE_W-1){1'b1}}};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = B_TURN;
                end
            end
            B_TURN:
            begin
                state_next = B_SCALE;
            end
            B_SCALE:
            begin
                state_next = B_ANGLE;
            end
            B_ANGLE:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            med_reg <= q_data;
        end
        if (state_reg == B_TURN)
        begin
            prod_reg <= PROD_W'(med_reg) * PROD_W'(cfg.duty_gain);
        end
        if (state_reg == B_SCALE)
        begin
            duty_reg      <= prod_reg[PROD_W-1:GAIN_W];
            span_prod_reg <= SPAN_PROD_W'(extra_turns) * SPAN_PROD_W'(cfg.turn_span_q8);
        end
        if ((state_reg == B_ANGLE) && out_free)
        begin
            median_width    <= med_reg;
            turn_count      <= turns_reg;
            unwrapped_angle <= angle_clamped;
            saturated       <= sat_reg || angle_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            last_med_reg  <= '0;
            turns_reg     <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_TURN)
            begin
                last_med_reg <= med_reg;
                turns_reg    <= turns_next;
                sat_reg      <= turn_sat;
            end
            if ((state_reg == B_ANGLE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### sv/median_wrap_angle_tracker.sv
// ----------------------------------------------------------------------------
// median_wrap_angle_tracker
// Median-filtered feedback pulse width to unwrapped angle with turn counting.
// ----------------------------------------------------------------------------
//
//  Channel   | Handshake          | Word
//  ----------+--------------------+--------------------------------------------
//  input     | push / full        | fb_width
//  result    | pop / empty        | median_width, turn_count, unwrapped_angle,
//            |                    | saturated
//  config    | wr_en (no wait)    | wr_index, wr_data
//
//  Order: the front takes a word, then ranks one window entry per cycle until
//  the median is found, then hands it to the queue and takes no new word
//  until the queue accepts it. The back steps through pop, turn update, scale
//  and angle for each median. Reset clears the window, turn count and queue
//  and empties the result register at once; no clearing pass. A stalled
//  result holds the back, the queue absorbs two medians, and only then does
//  full stay high.
//
`include "median_wrap_angle_tracker_macros.svh"

module median_wrap_angle_tracker (
    input  logic                            clk,
    input  logic                            rst_n,
    // input words
    input  logic                            push,
    output logic                            full,
    input  logic [mwat_pkg::PULSE_W-1:0]    fb_width,
    // result words
    output logic                            empty,
    input  logic                            pop,
    output logic [mwat_pkg::PULSE_W-1:0]    median_width,
    output logic signed [mwat_pkg::TURN_W-1:0]  turn_count,
    output logic signed [mwat_pkg::ANGLE_W-1:0] unwrapped_angle,
    output logic                            saturated,
    // configuration writes
    input  logic                            wr_en,
    input  logic [mwat_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [mwat_pkg::CFG_DATA_W-1:0] wr_data
);
    import mwat_pkg::*;

    cfg_t               cfg_reg;
    q_stat_t            q_stat;
    logic               q_push;
    logic               q_pop;
    logic [PULSE_W-1:0] q_wr_data;
    logic [PULSE_W-1:0] q_rd_data;

    // Register file: drop value bits above each register's width, ignore
    // indexes past the last register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.duty_gain       <= GAIN_W'(19085);
            cfg_reg.jump_threshold  <= PULSE_W'(2600);
            cfg_reg.duty_min_q8     <= Q8_W'(742);
            cfg_reg.duty_max_q8     <= Q8_W'(24858);
            cfg_reg.start_offset_q8 <= '0;
            cfg_reg.turn_span_q8    <= Q8_W'(256);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_DUTY_GAIN:    cfg_reg.duty_gain       <= wr_data[GAIN_W-1:0];
                REG_JUMP_THRESH:  cfg_reg.jump_threshold  <= wr_data[PULSE_W-1:0];
                REG_DUTY_MIN:     cfg_reg.duty_min_q8     <= wr_data[Q8_W-1:0];
                REG_DUTY_MAX:     cfg_reg.duty_max_q8     <= wr_data[Q8_W-1:0];
                REG_START_OFFSET: cfg_reg.start_offset_q8 <= wr_data[Q8_W-1:0];
                REG_TURN_SPAN:    cfg_reg.turn_span_q8    <= wr_data[Q8_W-1:0];
                default:          ;
            endcase
        end
    end

    // Front: window write and median search.
    mwat_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .fb_width    (fb_width),
        .full        (full),
        .q_full      (q_stat.full),
        .q_push      (q_push),
        .q_data      (q_wr_data)
    );

    // Median queue decouples ranking from the angle math.
    mwat_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wr_data (q_wr_data),
        .rd      (q_pop),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    // Back: turn count, duty scaling, unwrap and result word register.
    mwat_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .q_empty         (q_stat.empty),
        .q_data          (q_rd_data),
        .q_pop           (q_pop),
        .empty           (empty),
        .pop             (pop),
        .median_width    (median_width),
        .turn_count      (turn_count),
        .unwrapped_angle (unwrapped_angle),
        .saturated       (saturated)
    );

    // Front only hands a median over when the queue has room.
    `MWAT_ASSERT_SAME(a_q_no_overflow, q_push, !q_stat.full, "median pushed into full queue")
    // Back only takes a median that is there.
    `MWAT_ASSERT_SAME(a_q_no_underflow, q_pop, !q_stat.empty, "median popped from empty queue")
    // An accepted word puts the front into ranking, so full goes high after the accept.
    `MWAT_ASSERT_NEXT(a_front_busy, push && !full, full, "front idle right after accept")

endmodule
